// File: rtl/core/readout_channel_map_lookup_core_assert.svh
// Assertion macros used by the core RTL.
`ifndef READOUT_CHANNEL_MAP_LOOKUP_CORE_ASSERT_SVH
`define READOUT_CHANNEL_MAP_LOOKUP_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// cond must hold whenever trig holds
`define RCML_ASSERT_IMPLIES(label, clk, rst, trig, cond, msg) \
label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
   else $error(msg);

// cond must hold in the cycle after trig
`define RCML_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
   else $error(msg);

`else

`define RCML_ASSERT_IMPLIES(label, clk, rst, trig, cond, msg)
`define RCML_ASSERT_NEXT(label, clk, rst, trig, cond, msg)

`endif

`endif

// File: rtl/core/rcml_pkg.sv
package rcml_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;

   // request kinds (req_tuser)
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;
   localparam int COUNT_W     = 7;

   localparam logic signed [8:0] MISS_NUMBER = -9'sd99;

   typedef struct packed {
      logic [3:0] crate;
      logic [4:0] board;
      logic [3:0] channel;
      logic [5:0] cell_id;
      logic [1:0] side;
      logic [7:0] number;
   } entry_type;

endpackage

// File: rtl/core/readout_channel_map_lookup_core.sv
// Readout channel map lookup core.
// Maps a digitizer address (crate, board, channel) to a detector position
// (cell, tube side, tube number) through a table of TABLE_ENTRIES entries.
// Request beats (req_*): req_tuser selects a table write or a lookup. A write
// stores one entry at entry_index and gives no response beat. A lookup searches
// entries 0 .. entry_count-1 (count saturates at TABLE_ENTRIES), lowest index
// wins, and gives exactly one response beat: found=1 with the stored position,
// or found=0, cell/side 0, number -99.
// Lookup scan: the scan reads the entry RAM one entry per cycle through its
// single read port; a hit ends the scan early. One item is in work at a time.
// entry_count is written through csr_we/csr_wdata; the user must write it
// only while the core is idle, and the core does not enforce this.
// Reset clears entry_count and all control state; table contents are
// undefined until written and must be loaded before they are searched.
// The response sits in an output register; the next request is accepted
// while it waits. If rsp_tready stays low, a finished lookup holds its
// result and the core stops taking requests until the register frees up.
module readout_channel_map_lookup_core #(
   parameter int TABLE_ENTRIES = rcml_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [rcml_pkg::COUNT_W-1:0]     csr_wdata,   // entry_count
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [5:0] entry_index, [9:6] hit_crate, [14:10] hit_board,
   // [18:15] hit_channel, [24:19] cell_in, [26:25] side_in,
   // [34:27] tube_number_in, [39:35] zero
   input  logic [rcml_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [0:0]                       req_tuser,   // [0] opcode
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [5:0] cell_out, [7:6] side_out, [16:8] tube_number_out (signed),
   // [23:17] zero
   output logic [rcml_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]                       rsp_tuser    // [0] found
);

   `include "readout_channel_map_lookup_core_assert.svh"

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   // request fields
   logic [5:0] f_index;
   logic [3:0] f_crate;
   logic [4:0] f_board;
   logic [3:0] f_channel;
   logic [5:0] f_cell;
   logic [1:0] f_side;
   logic [7:0] f_number;

   assign f_index   = req_tdata[5:0];
   assign f_crate   = req_tdata[9:6];
   assign f_board   = req_tdata[14:10];
   assign f_channel = req_tdata[18:15];
   assign f_cell    = req_tdata[24:19];
   assign f_side    = req_tdata[26:25];
   assign f_number  = req_tdata[34:27];

   // control state
   logic [1:0]                   state_ff, state_in;
   logic [rcml_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [CW-1:0]                limit_ff, limit_in;
   logic [CW-1:0]                issue_ff, issue_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic                         chk_last_ff, chk_last_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // payload
   logic [3:0]              key_crate_ff, key_crate_in;
   logic [4:0]              key_board_ff, key_board_in;
   logic [3:0]              key_channel_ff, key_channel_in;
   logic                    res_found_ff, res_found_in;
   logic [5:0]              res_cell_ff, res_cell_in;
   logic [1:0]              res_side_ff, res_side_in;
   logic signed [8:0]       res_tube_ff, res_tube_in;
   logic                    out_found_ff, out_found_in;
   logic [5:0]              out_cell_ff, out_cell_in;
   logic [1:0]              out_side_ff, out_side_in;
   logic signed [8:0]       out_tube_ff, out_tube_in;

   // RAM hookup
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   rcml_pkg::entry_type wr_entry;
   logic                rd_en;
   rcml_pkg::entry_type rd_entry;

   logic          req_fire;
   logic          issue_en;
   logic          chk_match;
   logic          scan_done;
   logic          out_free;
   logic [CW-1:0] lim_calc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // saturate the search count at the table depth
   always_comb begin
      if (32'(count_ff) > TABLE_ENTRIES) begin
         lim_calc = CW'(TABLE_ENTRIES);
      end else begin
         lim_calc = CW'(count_ff);
      end
   end

   // table writes go straight into the RAM; out-of-range slots are dropped
   assign wr_en = req_fire && (req_tuser[0] == rcml_pkg::OP_WRITE)
                  && (32'(f_index) < TABLE_ENTRIES);
   always_comb begin
      logic [AW+5:0] idx_wide;
      idx_wide = (AW + 6)'(f_index);
      wr_addr  = idx_wide[AW-1:0];
   end
   assign wr_entry = '{crate: f_crate, board: f_board, channel: f_channel,
                       cell_id: f_cell, side: f_side, number: f_number};

   assign issue_en  = (state_ff == ST_SCAN) && (issue_ff < limit_ff);
   assign rd_en     = issue_en;
   assign chk_match = chk_vld_ff
                      && (rd_entry.crate == key_crate_ff)
                      && (rd_entry.board == key_board_ff)
                      && (rd_entry.channel == key_channel_ff);
   assign scan_done = chk_vld_ff && (chk_match || chk_last_ff);

   rcml_entry_ram #(
      .DEPTH (TABLE_ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = csr_we ? csr_wdata : count_ff;
      limit_in       = limit_ff;
      issue_in       = issue_ff;
      chk_vld_in     = 1'b0;
      chk_last_in    = chk_last_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      key_crate_in   = key_crate_ff;
      key_board_in   = key_board_ff;
      key_channel_in = key_channel_ff;
      res_found_in   = res_found_ff;
      res_cell_in    = res_cell_ff;
      res_side_in    = res_side_ff;
      res_tube_in    = res_tube_ff;
      out_found_in   = out_found_ff;
      out_cell_in    = out_cell_ff;
      out_side_in    = out_side_ff;
      out_tube_in    = out_tube_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser[0] == rcml_pkg::OP_LOOKUP)) begin
               key_crate_in   = f_crate;
               key_board_in   = f_board;
               key_channel_in = f_channel;
               limit_in       = lim_calc;
               issue_in       = '0;
               if (lim_calc == '0) begin
                  // nothing to search: straight miss
                  res_found_in = 1'b0;
                  res_cell_in  = '0;
                  res_side_in  = '0;
                  res_tube_in  = rcml_pkg::MISS_NUMBER;
                  state_in     = ST_FLUSH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_en && !scan_done) begin
               issue_in    = issue_ff + CW'(1);
               chk_vld_in  = 1'b1;
               chk_last_in = (issue_ff == (limit_ff - CW'(1)));
            end
            if (chk_match) begin
               res_found_in = 1'b1;
               res_cell_in  = rd_entry.cell_id;
               res_side_in  = rd_entry.side;
               res_tube_in  = $signed({1'b0, rd_entry.number});
               state_in     = ST_FLUSH;
            end else if (scan_done) begin
               res_found_in = 1'b0;
               res_cell_in  = '0;
               res_side_in  = '0;
               res_tube_in  = rcml_pkg::MISS_NUMBER;
               state_in     = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_found_in = res_found_ff;
               out_cell_in  = res_cell_ff;
               out_side_in  = res_side_ff;
               out_tube_in  = res_tube_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= '0;
         issue_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         chk_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         chk_last_ff  <= chk_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_crate_ff   <= key_crate_in;
      key_board_ff   <= key_board_in;
      key_channel_ff <= key_channel_in;
      res_found_ff   <= res_found_in;
      res_cell_ff    <= res_cell_in;
      res_side_ff    <= res_side_in;
      res_tube_ff    <= res_tube_in;
      out_found_ff   <= out_found_in;
      out_cell_ff    <= out_cell_in;
      out_side_ff    <= out_side_in;
      out_tube_ff    <= out_tube_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = {7'd0, out_tube_ff, out_side_ff, out_cell_ff};

   // checks
   `RCML_ASSERT_IMPLIES(a_hit_tube_positive, clock, reset,
      rsp_valid_ff && out_found_ff, out_tube_ff[8] == 1'b0,
      "hit returned a negative tube number")
   `RCML_ASSERT_IMPLIES(a_miss_fields, clock, reset,
      rsp_valid_ff && !out_found_ff,
      (out_cell_ff == '0) && (out_side_ff == '0)
      && (out_tube_ff == rcml_pkg::MISS_NUMBER),
      "miss beat carries wrong fields")
   `RCML_ASSERT_IMPLIES(a_check_in_scan, clock, reset,
      chk_vld_ff, state_ff == ST_SCAN,
      "entry compare outside scan")
   `RCML_ASSERT_IMPLIES(a_issue_bound, clock, reset,
      state_ff == ST_SCAN, issue_ff <= limit_ff,
      "scan address ran past the search limit")
   `RCML_ASSERT_NEXT(a_scan_leaves, clock, reset,
      state_ff == ST_SCAN && scan_done, state_ff == ST_FLUSH,
      "finished scan did not move to result hand-off")

endmodule

// File: rtl/core/rcml_entry_ram.sv
module rcml_entry_ram #(
   parameter int DEPTH = rcml_pkg::TABLE_ENTRIES_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  rcml_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output rcml_pkg::entry_type rd_data
);

   rcml_pkg::entry_type mem [DEPTH];
   rcml_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered synchronous read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
